[hdl/ccp_pkg.sv]
`default_nettype none
package ccp_pkg;

  localparam int COORD_W    = 24;
  localparam int RAD_W      = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int LEN_W      = RAD_W + 1;
  localparam int SQ_W       = 2 * LEN_W;
  localparam int L2_W       = SQ_W + 1;
  localparam int SD_W       = RAD_W + LEN_W;
  localparam int R_W        = 2 * SD_W + 2;
  localparam int ACC_W      = R_W + 6;
  localparam int ROOT_STEPS = RAD_W;
  localparam int PUSH_W     = RAD_W + 1;
  localparam logic [RAD_W-1:0] OWN_RADIUS_RST = RAD_W'(256);

  typedef struct packed {
    logic                       hit;
    logic                       zero;
    logic                       neg_x;
    logic                       neg_z;
    logic signed [COORD_W-1:0]  my_x;
    logic signed [COORD_W-1:0]  my_z;
    logic [RAD_W-1:0]           speed;
  } side_t;

endpackage
`default_nettype wire

[hdl/ccp_front.sv]
`default_nettype none
module ccp_front (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              en,
  input  wire                              in_valid,
  input  wire  [ccp_pkg::RAD_W-1:0]        own_radius,
  input  wire  signed [ccp_pkg::COORD_W-1:0] my_x,
  input  wire  signed [ccp_pkg::COORD_W-1:0] my_z,
  input  wire  signed [ccp_pkg::COORD_W-1:0] other_x,
  input  wire  signed [ccp_pkg::COORD_W-1:0] other_z,
  input  wire  [ccp_pkg::RAD_W-1:0]        other_radius,
  input  wire  [ccp_pkg::RAD_W-1:0]        push_speed,
  output logic                             f_valid,
  output ccp_pkg::side_t                   f_side,
  output logic [ccp_pkg::L2_W-1:0]         f_l2,
  output logic [ccp_pkg::R_W-1:0]          f_rx,
  output logic [ccp_pkg::R_W-1:0]          f_rz,
  output logic [ccp_pkg::RAD_W-1:0]        f_speed
);

  // stage 1: differences and radius sum
  logic                               v1;
  logic signed [ccp_pkg::DIFF_W-1:0]  dx1, dz1;
  logic [ccp_pkg::LEN_W-1:0]          rsum1;
  logic [ccp_pkg::RAD_W-1:0]          s1;
  logic signed [ccp_pkg::COORD_W-1:0] mx1, mz1;

  // stage 2: magnitudes and box gate
  logic                               v2, gate2, nx2, nz2;
  logic [ccp_pkg::LEN_W-1:0]          ax2, az2, rsum2;
  logic [ccp_pkg::RAD_W-1:0]          s2;
  logic signed [ccp_pkg::COORD_W-1:0] mx2, mz2;

  // stage 3: products
  logic                               v3, gate3, nx3, nz3;
  logic [ccp_pkg::SQ_W-1:0]           axx3, azz3, rss3;
  logic [ccp_pkg::SD_W-1:0]           sx3, sz3;
  logic [ccp_pkg::RAD_W-1:0]          s3;
  logic signed [ccp_pkg::COORD_W-1:0] mx3, mz3;

  // stage 4: squared length, test, squared targets
  logic [2*ccp_pkg::SD_W-1:0]         qx4, qz4;

  logic [ccp_pkg::DIFF_W-1:0] ax_full, az_full;
  logic [ccp_pkg::L2_W-1:0]   l2_sum;

  assign ax_full = dx1[ccp_pkg::DIFF_W-1] ? ccp_pkg::DIFF_W'(-dx1) : ccp_pkg::DIFF_W'(dx1);
  assign az_full = dz1[ccp_pkg::DIFF_W-1] ? ccp_pkg::DIFF_W'(-dz1) : ccp_pkg::DIFF_W'(dz1);
  assign l2_sum  = ccp_pkg::L2_W'(axx3) + ccp_pkg::L2_W'(azz3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      f_valid <= 1'b0;
    end else if (en) begin
      v1      <= in_valid;
      v2      <= v1;
      v3      <= v2;
      f_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1   <= ccp_pkg::DIFF_W'(my_x) - ccp_pkg::DIFF_W'(other_x);
      dz1   <= ccp_pkg::DIFF_W'(my_z) - ccp_pkg::DIFF_W'(other_z);
      rsum1 <= ccp_pkg::LEN_W'(own_radius) + ccp_pkg::LEN_W'(other_radius);
      s1    <= push_speed;
      mx1   <= my_x;
      mz1   <= my_z;

      gate2 <= (ax_full <= ccp_pkg::DIFF_W'(rsum1)) && (az_full <= ccp_pkg::DIFF_W'(rsum1));
      ax2   <= ax_full[ccp_pkg::LEN_W-1:0];
      az2   <= az_full[ccp_pkg::LEN_W-1:0];
      nx2   <= dx1[ccp_pkg::DIFF_W-1];
      nz2   <= dz1[ccp_pkg::DIFF_W-1];
      rsum2 <= rsum1;
      s2    <= s1;
      mx2   <= mx1;
      mz2   <= mz1;

      axx3  <= ccp_pkg::SQ_W'(ax2) * ccp_pkg::SQ_W'(ax2);
      azz3  <= ccp_pkg::SQ_W'(az2) * ccp_pkg::SQ_W'(az2);
      rss3  <= ccp_pkg::SQ_W'(rsum2) * ccp_pkg::SQ_W'(rsum2);
      sx3   <= ccp_pkg::SD_W'(s2) * ccp_pkg::SD_W'(ax2);
      sz3   <= ccp_pkg::SD_W'(s2) * ccp_pkg::SD_W'(az2);
      gate3 <= gate2;
      nx3   <= nx2;
      nz3   <= nz2;
      s3    <= s2;
      mx3   <= mx2;
      mz3   <= mz2;

      f_l2        <= l2_sum;
      f_side.hit  <= gate3 && (l2_sum <= ccp_pkg::L2_W'(rss3));
      f_side.zero <= (l2_sum == '0);
      f_side.neg_x <= nx3;
      f_side.neg_z <= nz3;
      f_side.my_x <= mx3;
      f_side.my_z <= mz3;
      f_side.speed <= s3;
      f_speed     <= s3;
      qx4 <= (2*ccp_pkg::SD_W)'(sx3) * (2*ccp_pkg::SD_W)'(sx3);
      qz4 <= (2*ccp_pkg::SD_W)'(sz3) * (2*ccp_pkg::SD_W)'(sz3);
    end
  end

  assign f_rx = {qx4, 2'b00};
  assign f_rz = {qz4, 2'b00};

endmodule
`default_nettype wire

[hdl/ccp_root.sv]
`default_nettype none
// Rounded quotient s*d/sqrt(l2), one result bit per stage, largest m <= s
// with (2m-1)^2 * l2 <= r. A tracks (2m-1)^2*l2 and B tracks (2m-1)*l2.
module ccp_root (
  input  wire                          clk,
  input  wire                          en,
  input  wire  [ccp_pkg::L2_W-1:0]     l2,
  input  wire  [ccp_pkg::R_W-1:0]      r,
  input  wire  [ccp_pkg::RAD_W-1:0]    s,
  output logic [ccp_pkg::RAD_W-1:0]    res
);

  logic signed [ccp_pkg::ACC_W-1:0] acc_a [0:ccp_pkg::ROOT_STEPS];
  logic signed [ccp_pkg::ACC_W-1:0] acc_b [0:ccp_pkg::ROOT_STEPS];
  logic signed [ccp_pkg::ACC_W-1:0] len2  [0:ccp_pkg::ROOT_STEPS];
  logic signed [ccp_pkg::ACC_W-1:0] targ  [0:ccp_pkg::ROOT_STEPS];
  logic [ccp_pkg::RAD_W-1:0]        cap   [0:ccp_pkg::ROOT_STEPS];
  logic [ccp_pkg::RAD_W-1:0]        part  [0:ccp_pkg::ROOT_STEPS];

  assign len2[0]  = ccp_pkg::ACC_W'(l2);
  assign targ[0]  = ccp_pkg::ACC_W'(r);
  assign acc_a[0] = ccp_pkg::ACC_W'(l2);
  assign acc_b[0] = -ccp_pkg::ACC_W'(l2);
  assign cap[0]   = s;
  assign part[0]  = '0;

  for (genvar i = 0; i < ccp_pkg::ROOT_STEPS; i++) begin : g_step
    localparam int B = ccp_pkg::ROOT_STEPS - 1 - i;
    logic [ccp_pkg::RAD_W-1:0]        trial;
    logic signed [ccp_pkg::ACC_W-1:0] a_try;
    logic                             ok;

    assign trial = part[i] | (ccp_pkg::RAD_W'(1) << B);
    assign a_try = acc_a[i] + (acc_b[i] <<< (B + 2)) + (len2[i] <<< (2*B + 2));
    assign ok    = (a_try <= targ[i]) && (trial <= cap[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        part[i+1]  <= ok ? trial : part[i];
        acc_a[i+1] <= ok ? a_try : acc_a[i];
        acc_b[i+1] <= ok ? acc_b[i] + (len2[i] <<< (B + 1)) : acc_b[i];
        len2[i+1]  <= len2[i];
        targ[i+1]  <= targ[i];
        cap[i+1]   <= cap[i];
      end
    end
  end

  assign res = part[ccp_pkg::ROOT_STEPS];

endmodule
`default_nettype wire

[hdl/circle_collision_pushback_core.sv]
`default_nettype none
// Throughput: one word per cycle unless the output stalls; 4 front stages, 16 root
// stages (one result bit each), one output stage. A stalled output holds the whole pipeline.
// Reset (rst, synchronous): all valid bits clear, own_radius returns to 256.
module circle_collision_pushback_core (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [ccp_pkg::RAD_W-1:0]          cfg_wdata,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  signed [ccp_pkg::COORD_W-1:0] my_x,
  input  wire  signed [ccp_pkg::COORD_W-1:0] my_z,
  input  wire  signed [ccp_pkg::COORD_W-1:0] other_x,
  input  wire  signed [ccp_pkg::COORD_W-1:0] other_z,
  input  wire  [ccp_pkg::RAD_W-1:0]          other_radius,
  input  wire  [ccp_pkg::RAD_W-1:0]          push_speed,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               hit,
  output logic signed [ccp_pkg::COORD_W-1:0] new_x,
  output logic signed [ccp_pkg::COORD_W-1:0] new_z
);

  logic                           en;
  logic [ccp_pkg::RAD_W-1:0]      own_radius;
  logic                           f_valid;
  ccp_pkg::side_t                 f_side;
  logic [ccp_pkg::L2_W-1:0]       f_l2;
  logic [ccp_pkg::R_W-1:0]        f_rx, f_rz;
  logic [ccp_pkg::RAD_W-1:0]      f_speed;
  logic [ccp_pkg::RAD_W-1:0]      res_x, res_z;
  logic                           vline [0:ccp_pkg::ROOT_STEPS];
  ccp_pkg::side_t                 sline [0:ccp_pkg::ROOT_STEPS];
  ccp_pkg::side_t                 sd;
  logic [ccp_pkg::RAD_W-1:0]      mag_x, mag_z;
  logic signed [ccp_pkg::PUSH_W-1:0] px, pz;
  logic signed [ccp_pkg::DIFF_W-1:0] sum_x, sum_z;
  logic signed [ccp_pkg::COORD_W-1:0] sat_x, sat_z;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_radius <= ccp_pkg::OWN_RADIUS_RST;
    end else if (cfg_we) begin
      own_radius <= cfg_wdata;
    end
  end

  ccp_front u_front (
    .clk, .rst, .en, .in_valid, .own_radius,
    .my_x, .my_z, .other_x, .other_z, .other_radius, .push_speed,
    .f_valid, .f_side, .f_l2, .f_rx, .f_rz, .f_speed
  );

  ccp_root u_root_x (.clk, .en, .l2(f_l2), .r(f_rx), .s(f_speed), .res(res_x));
  ccp_root u_root_z (.clk, .en, .l2(f_l2), .r(f_rz), .s(f_speed), .res(res_z));

  assign vline[0] = f_valid;
  assign sline[0] = f_side;

  for (genvar k = 0; k < ccp_pkg::ROOT_STEPS; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) begin
        vline[k+1] <= 1'b0;
      end else if (en) begin
        vline[k+1] <= vline[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sline[k+1] <= sline[k];
      end
    end
  end

  assign sd = sline[ccp_pkg::ROOT_STEPS];

  // coincident bodies push straight along +z
  always_comb begin
    mag_x = sd.zero ? '0 : res_x;
    mag_z = sd.zero ? sd.speed : res_z;
    px = sd.neg_x ? -ccp_pkg::PUSH_W'(mag_x) : ccp_pkg::PUSH_W'(mag_x);
    pz = sd.neg_z ? -ccp_pkg::PUSH_W'(mag_z) : ccp_pkg::PUSH_W'(mag_z);
    if (!sd.hit) begin
      px = '0;
      pz = '0;
    end
    sum_x = ccp_pkg::DIFF_W'(sd.my_x) + ccp_pkg::DIFF_W'(px);
    sum_z = ccp_pkg::DIFF_W'(sd.my_z) + ccp_pkg::DIFF_W'(pz);
    sat_x = sum_x[ccp_pkg::COORD_W-1:0];
    sat_z = sum_z[ccp_pkg::COORD_W-1:0];
    if (sum_x[ccp_pkg::DIFF_W-1] != sum_x[ccp_pkg::COORD_W-1]) begin
      sat_x = {sum_x[ccp_pkg::DIFF_W-1], {(ccp_pkg::COORD_W-1){!sum_x[ccp_pkg::DIFF_W-1]}}};
    end
    if (sum_z[ccp_pkg::DIFF_W-1] != sum_z[ccp_pkg::COORD_W-1]) begin
      sat_z = {sum_z[ccp_pkg::DIFF_W-1], {(ccp_pkg::COORD_W-1){!sum_z[ccp_pkg::DIFF_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vline[ccp_pkg::ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit   <= sd.hit;
      new_x <= sat_x;
      new_z <= sat_z;
    end
  end

endmodule
`default_nettype wire

[hdl/ccp_checker.sv]
`default_nettype none
module ccp_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                in_stall,
  input wire                                out_valid,
  input wire                                out_stall,
  input wire                                hit,
  input wire signed [ccp_pkg::COORD_W-1:0]  new_x,
  input wire signed [ccp_pkg::COORD_W-1:0]  new_z
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(hit) && $stable(new_x) && $stable(new_z))
    else $error("result word changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word present after reset");

endmodule

bind circle_collision_pushback_core ccp_checker u_ccp_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .hit, .new_x, .new_z
);
`default_nettype wire
